@@ hdl/lpmr_pkg.sv @@
// Shared types, sizes and codes of the length-prefixed message ring.
package lpmr_pkg;

  // Size of the byte store and derived widths.
  localparam int STORE_BYTES = 1024;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CAP_W       = 11;
  localparam int CMP_W       = (ADDR_W + 1 > CAP_W) ? ADDR_W + 1 : CAP_W;

  // Largest capacity that the store and the register can both express.
  localparam int CAP_LIMIT = (STORE_BYTES < 2047) ? STORE_BYTES : 2047;
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(CAP_LIMIT);
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'((CAP_LIMIT < 1024) ? CAP_LIMIT : 1024);

  // Queue between the front and back ends; depth is a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Beat layout on the stream ports.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_USED_W  = 8 + 8 + CAP_W;

  // Operation codes on the input stream.
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Command kinds after classification.
  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BAD_SEQ = 2'd3;

  // One classified command as it sits in the queue.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] length;
    logic [7:0] data;
    logic       len_zero;
    logic [8:0] need;
  } cmd_t;

endpackage

@@ hdl/lpmr_ram.sv @@
// Generic single-port RAM with registered read data.
module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: a write, or a read whose data appears next cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ hdl/lpmr_front.sv @@
// Front end: accepts input beats, classifies them and queues the commands.
module lpmr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,  // length[7:0], data_byte[15:8]
  input  logic [1:0]            s_tuser,  // operation[1:0]
  output logic                  q_valid,
  output lpmr_pkg::cmd_t        q_cmd,
  input  logic                  q_pop
);

  import lpmr_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  cmd_t              cls;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  // Classify the operation and precompute the space a message needs.
  always_comb begin
    cls.length   = s_tdata[7:0];
    cls.data     = s_tdata[15:8];
    cls.len_zero = (s_tdata[7:0] == 8'd0);
    cls.need     = {1'b0, s_tdata[7:0]} + 9'd1;
    unique case (s_tuser)
      OP_BEGIN: cls.kind = KIND_BEGIN;
      OP_DATA:  cls.kind = KIND_DATA;
      OP_READ:  cls.kind = KIND_READ;
      default:  cls.kind = KIND_BAD;
    endcase
  end

  assign s_tready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_cmd    = entries[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && q_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/lpmr_back.sv @@
// Back end: executes queued commands against the ring store and registers the results.
module lpmr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lpmr_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic                        q_valid,
  input  lpmr_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,  // read_byte[7:0], message_length[15:8],
                                                // free_bytes[26:16], zero[31:27]
  output logic [1:0]                  m_tuser,  // status[1:0]
  output logic                        m_tlast   // last_of_message
);

  import lpmr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_BYTE = 2'd2;

  logic [1:0]        state, state_next;
  logic [CAP_W-1:0]  cap;
  logic [ADDR_W-1:0] wp, wp_next;
  logic [ADDR_W-1:0] rp, rp_next;
  logic [CAP_W-1:0]  committed, committed_next;
  logic [CAP_W-1:0]  reserved, reserved_next;
  logic [7:0]        wr_rem, wr_rem_next;
  logic              wr_open, wr_open_next;
  logic [7:0]        rd_rem, rd_rem_next;
  logic              rd_open, rd_open_next;
  logic [7:0]        cur_len, cur_len_next;

  logic              out_load;
  logic [1:0]        out_status, res_status;
  logic [7:0]        out_rbyte, res_rbyte;
  logic [7:0]        out_mlen, res_mlen;
  logic              out_last, res_last;
  logic [CAP_W-1:0]  out_free;
  logic [CAP_W-1:0]  free_now;
  logic              slot_free;

  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  // Next pointer position, wrapping at the capacity.
  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p,
                                                input logic [CAP_W-1:0]  c);
    logic [CMP_W-1:0] n;
    n = CMP_W'(p) + CMP_W'(1);
    return (n >= CMP_W'(c)) ? '0 : n[ADDR_W-1:0];
  endfunction

  // Bytes neither committed nor reserved.
  function automatic logic [CAP_W-1:0] free_of(input logic [CAP_W-1:0] c,
                                               input logic [CAP_W-1:0] r,
                                               input logic [CAP_W-1:0] k);
    logic [CAP_W:0] used;
    used = {1'b0, c} + {1'b0, r};
    return (used >= {1'b0, k}) ? '0 : k - used[CAP_W-1:0];
  endfunction

  // Capacity as the ring uses it, held within the store's bounds.
  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] r;
    r = v;
    if (v < CAP_MIN) begin
      r = CAP_MIN;
    end else if (v > CAP_MAX) begin
      r = CAP_MAX;
    end
    return r;
  endfunction

  assign free_now  = free_of(committed, reserved, cap);
  assign slot_free = !m_tvalid || m_tready;

  // Command execution and the read sequencer.
  always_comb begin
    state_next     = state;
    wp_next        = wp;
    rp_next        = rp;
    committed_next = committed;
    reserved_next  = reserved;
    wr_rem_next    = wr_rem;
    wr_open_next   = wr_open;
    rd_rem_next    = rd_rem;
    rd_open_next   = rd_open;
    cur_len_next   = cur_len;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    res_status     = ST_OK;
    res_rbyte      = 8'd0;
    res_mlen       = 8'd0;
    res_last       = 1'b0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = wp;
    ram_wdata      = q_cmd.data;

    unique case (state)
      S_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            KIND_BEGIN: begin
              out_load = 1'b1;
              if (wr_open) begin
                res_status = ST_BAD_SEQ;
              end else if (free_now < CAP_W'(q_cmd.need)) begin
                res_status = ST_NO_ROOM;
              end else begin
                // Store the header; commit an empty message, else reserve it all.
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = q_cmd.length;
                wp_next   = advance(wp, cap);
                if (q_cmd.len_zero) begin
                  committed_next = committed + CAP_W'(1);
                  res_last       = 1'b1;
                end else begin
                  reserved_next = CAP_W'(q_cmd.need);
                  wr_rem_next   = q_cmd.length;
                  wr_open_next  = 1'b1;
                end
              end
            end
            KIND_DATA: begin
              out_load = 1'b1;
              if (!wr_open) begin
                res_status = ST_BAD_SEQ;
              end else begin
                ram_en      = 1'b1;
                ram_we      = 1'b1;
                wp_next     = advance(wp, cap);
                wr_rem_next = wr_rem - 8'd1;
                if (wr_rem == 8'd1) begin
                  // Last byte: the reserved space becomes readable.
                  committed_next = committed + reserved;
                  reserved_next  = '0;
                  wr_open_next   = 1'b0;
                  res_last       = 1'b1;
                end
              end
            end
            KIND_READ: begin
              if (!rd_open && committed == '0) begin
                out_load   = 1'b1;
                res_status = ST_EMPTY;
              end else if (!rd_open) begin
                // Fetch the header of the next message.
                ram_en         = 1'b1;
                ram_addr       = rp;
                rp_next        = advance(rp, cap);
                committed_next = committed - CAP_W'(1);
                state_next     = S_HDR;
              end else if (rd_rem != 8'd0 && committed != '0) begin
                ram_en         = 1'b1;
                ram_addr       = rp;
                rp_next        = advance(rp, cap);
                committed_next = committed - CAP_W'(1);
                state_next     = S_BYTE;
              end else begin
                out_load     = 1'b1;
                rd_open_next = 1'b0;
                res_last     = 1'b1;
                res_mlen     = cur_len;
              end
            end
            default: begin
              out_load   = 1'b1;
              res_status = ST_BAD_SEQ;
            end
          endcase
        end
      end
      S_HDR: begin
        cur_len_next = ram_rdata;
        rd_rem_next  = ram_rdata;
        if (ram_rdata != 8'd0 && committed != '0) begin
          // Open the message and fetch its first byte.
          rd_open_next   = 1'b1;
          ram_en         = 1'b1;
          ram_addr       = rp;
          rp_next        = advance(rp, cap);
          committed_next = committed - CAP_W'(1);
          state_next     = S_BYTE;
        end else begin
          rd_open_next = 1'b0;
          out_load     = 1'b1;
          res_last     = 1'b1;
          res_mlen     = ram_rdata;
          state_next   = S_IDLE;
        end
      end
      S_BYTE: begin
        out_load    = 1'b1;
        res_rbyte   = ram_rdata;
        res_mlen    = cur_len;
        rd_rem_next = rd_rem - 8'd1;
        if (rd_rem == 8'd1) begin
          rd_open_next = 1'b0;
          res_last     = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state; a capacity write empties the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CAP_RESET;
      wp        <= '0;
      rp        <= '0;
      committed <= '0;
      reserved  <= '0;
      wr_rem    <= '0;
      wr_open   <= 1'b0;
      rd_rem    <= '0;
      rd_open   <= 1'b0;
      cur_len   <= '0;
      m_tvalid  <= 1'b0;
    end else if (cfg_we) begin
      cap       <= clamp_cap(cfg_wdata);
      wp        <= '0;
      rp        <= '0;
      committed <= '0;
      reserved  <= '0;
      wr_rem    <= '0;
      wr_open   <= 1'b0;
      rd_rem    <= '0;
      rd_open   <= 1'b0;
      cur_len   <= '0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      rp        <= rp_next;
      committed <= committed_next;
      reserved  <= reserved_next;
      wr_rem    <= wr_rem_next;
      wr_open   <= wr_open_next;
      rd_rem    <= rd_rem_next;
      rd_open   <= rd_open_next;
      cur_len   <= cur_len_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_rbyte  <= res_rbyte;
      out_mlen   <= res_mlen;
      out_last   <= res_last;
      out_free   <= free_of(committed_next, reserved_next, cap);
    end
  end

  assign m_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), out_free, out_mlen, out_rbyte};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  lpmr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // An open write always holds reserved space.
  a_open_reserved: assert property (@(posedge clk) disable iff (rst)
    wr_open |-> reserved != '0)
    else $error("write open without reserved space");

  // Committed and reserved bytes never exceed the capacity.
  a_within_cap: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, committed} + {1'b0, reserved}) <= {1'b0, cap})
    else $error("ring over-subscribed");

  // While a read waits on the store the result register is empty.
  a_wait_empty: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !m_tvalid)
    else $error("result pending during store read");

  // A byte fetch always ends in a result.
  a_byte_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_BYTE && !cfg_we) |=> m_tvalid)
    else $error("byte read produced no result");

endmodule

@@ hdl/length_prefixed_message_ring.sv @@
// Top level of the length-prefixed message ring.
//
// A byte-wide circular store of variable-length messages, each kept as a
// length header followed by its bytes. Input beats are classified and
// queued by a front end (two commands deep) while a back end carries them
// out against a single-port store with registered read data. A begin-write
// or data beat, or any beat answered with an error status, is done in the
// idle state, so such beats stream at one per cycle while results are taken.
// A read that returns a byte passes the byte state, and one that opens a
// message passes the header state first (and ends there when the message
// has no bytes), because the header and then the first byte must each be
// fetched through the one store port in turn. The store needs no clearing
// after reset; writing the capacity register empties the ring but keeps
// the store contents, and must happen only while the ring is idle.
module length_prefixed_message_ring (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lpmr_pkg::CAP_W-1:0]  cfg_wdata,  // capacity
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,    // length[7:0], data_byte[15:8]
  input  logic [1:0]                  s_tuser,    // operation[1:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,    // read_byte[7:0], message_length[15:8],
                                                  // free_bytes[26:16], zero[31:27]
  output logic [1:0]                  m_tuser,    // status[1:0]
  output logic                        m_tlast     // last_of_message
);

  import lpmr_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // Accept and classify beats.
  lpmr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // Execute commands and deliver results.
  lpmr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
